[hw/rtl/rrts_pkg.sv]
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int TOTAL_W   = SLOT_W + 1;
    localparam int IDX_W     = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;

    typedef logic [1:0] status_t;

    localparam status_t ST_EMPTY = 2'd0;
    localparam status_t ST_READY = 2'd1;
    localparam status_t ST_RUN   = 2'd2;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_CREATE = 2'd1;
    localparam logic [1:0] MODE_EXIT   = 2'd2;
    localparam logic [1:0] MODE_JOIN   = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] last_slot;
    } item_t;

    typedef struct packed {
        logic              switched;
        logic [SLOT_W-1:0] from_slot;
        logic [SLOT_W-1:0] to_slot;
        logic              join_done;
        logic              sched_stopped;
    } result_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        status_t          data;
    } wr_t;

endpackage

[hw/rtl/rrts_slot_table.sv]
`timescale 1ns / 1ps

module rrts_slot_table (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [rrts_pkg::IDX_W-1:0] rd_addr,
    output rrts_pkg::status_t       rd_data,
    input  rrts_pkg::wr_t           wr
);

    rrts_pkg::status_t status_reg [rrts_pkg::MAX_SLOTS];

    assign rd_data = status_reg[rd_addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rrts_pkg::MAX_SLOTS; i++)
            begin
                status_reg[i] <= rrts_pkg::ST_EMPTY;
            end
        end
        else if (wr.en)
        begin
            status_reg[wr.addr] <= wr.data;
        end
    end

endmodule

[hw/rtl/round_robin_thread_scheduler.sv]
`timescale 1ns / 1ps
// Channel  Valid         Stall         Payload
// item     item_valid    item_stall    item   (mode, slot, last_slot)
// result   result_valid  result_stall  result (switched, from/to, join_done, stopped)
// The first create also writes slot 0 before its own slot.
// A tick first reduces the current slot modulo N, N the slot count, by subtraction
// in one shared adder, then scans one slot per cycle.
// Reset clears the slot table and all control state at once; no clearing pass.
// The result register frees the sequencer: a new item is taken while a result
// waits under stall.

module round_robin_thread_scheduler (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  rrts_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output rrts_pkg::result_t result
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_MOD     = 10'b0000000010,
        S_SCAN    = 10'b0000000100,
        S_RELEASE = 10'b0000001000,
        S_CLAIM   = 10'b0000010000,
        S_INIT    = 10'b0000100000,
        S_CREATE  = 10'b0001000000,
        S_EXIT    = 10'b0010000000,
        S_JOIN    = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } state_t;

    localparam int SW = rrts_pkg::SLOT_W;
    localparam int TW = rrts_pkg::TOTAL_W;
    localparam int IW = rrts_pkg::IDX_W;

    state_t                state_reg, state_next;
    rrts_pkg::item_t       item_reg, item_next;
    rrts_pkg::result_t     res_reg, res_next;
    rrts_pkg::result_t     out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [TW-1:0]         cand_reg, cand_next;
    logic [TW-1:0]         cnt_reg, cnt_next;
    logic [SW-1:0]         cur_reg, cur_next;
    logic [TW-1:0]         total_reg, total_next;
    logic                  enabled_reg, enabled_next;
    logic                  awaiting_reg, awaiting_next;
    logic                  main_init_reg, main_init_next;

    logic [IW-1:0]         rd_addr;
    rrts_pkg::status_t     rd_data;
    rrts_pkg::wr_t         wr;

    logic [TW-1:0]         addend;
    logic [TW-1:0]         sum;
    logic [TW-1:0]         step;
    logic                  reduce;
    logic                  slot_ok;
    logic                  cur_ok;
    logic [TW-1:0]         new_total;
    logic [TW-1:0]         slot_plus;

    rrts_slot_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign reduce  = (state_reg == S_MOD) && (cand_reg >= total_reg);
    assign addend  = reduce ? (~total_reg + TW'(1)) : TW'(1);
    assign sum     = cand_reg + addend;
    assign step    = (sum == total_reg) ? '0 : sum;

    assign slot_ok   = (32'(item_reg.slot) < rrts_pkg::MAX_SLOTS);
    assign cur_ok    = (32'(cur_reg) < rrts_pkg::MAX_SLOTS);
    assign slot_plus = TW'(item_reg.slot) + TW'(1);

    always_comb
    begin
        if ((32'(item_reg.last_slot) + 1) > rrts_pkg::MAX_SLOTS)
        begin
            new_total = TW'(rrts_pkg::MAX_SLOTS);
        end
        else
        begin
            new_total = TW'(item_reg.last_slot) + TW'(1);
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_SCAN:    rd_addr = IW'(cand_reg);
            S_RELEASE: rd_addr = IW'(cur_reg);
            default:   rd_addr = IW'(item_reg.slot);
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cand_next      = cand_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        total_next     = total_reg;
        enabled_next   = enabled_reg;
        awaiting_next  = awaiting_reg;
        main_init_next = main_init_reg;
        wr             = '0;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                    res_next  = '0;
                    case (item.mode)
                        rrts_pkg::MODE_TICK:
                        begin
                            cand_next = TW'(cur_reg);
                            if (!enabled_reg || total_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MOD;
                            end
                        end
                        rrts_pkg::MODE_CREATE:
                        begin
                            if (awaiting_reg && !main_init_reg)
                            begin
                                state_next = S_INIT;
                            end
                            else
                            begin
                                state_next = S_CREATE;
                            end
                        end
                        rrts_pkg::MODE_EXIT: state_next = S_EXIT;
                        default:             state_next = S_JOIN;
                    endcase
                end
            end

            S_MOD:
            begin
                if (reduce)
                begin
                    cand_next = sum;
                end
                else
                begin
                    cand_next  = step;
                    cnt_next   = TW'(1);
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (rd_data == rrts_pkg::ST_READY)
                begin
                    state_next = S_RELEASE;
                end
                else if (cnt_reg == total_reg)
                begin
                    enabled_next           = 1'b0;
                    awaiting_next          = 1'b1;
                    res_next.sched_stopped = 1'b1;
                    state_next             = S_DONE;
                end
                else
                begin
                    cand_next = step;
                    cnt_next  = cnt_reg + TW'(1);
                end
            end

            S_RELEASE:
            begin
                if (cur_ok && rd_data == rrts_pkg::ST_RUN)
                begin
                    wr.en   = 1'b1;
                    wr.addr = IW'(cur_reg);
                    wr.data = rrts_pkg::ST_READY;
                end
                state_next = S_CLAIM;
            end

            S_CLAIM:
            begin
                wr.en              = 1'b1;
                wr.addr            = IW'(cand_reg);
                wr.data            = rrts_pkg::ST_RUN;
                res_next.switched  = 1'b1;
                res_next.from_slot = cur_reg;
                res_next.to_slot   = SW'(cand_reg);
                cur_next           = SW'(cand_reg);
                state_next         = S_DONE;
            end

            S_INIT:
            begin
                wr.en          = 1'b1;
                wr.addr        = '0;
                wr.data        = rrts_pkg::ST_RUN;
                cur_next       = '0;
                main_init_next = 1'b1;
                state_next     = S_CREATE;
            end

            S_CREATE:
            begin
                if (awaiting_reg)
                begin
                    total_next    = new_total;
                    awaiting_next = 1'b0;
                    if (slot_plus == new_total)
                    begin
                        enabled_next = 1'b1;
                    end
                end
                else if (slot_plus == total_reg)
                begin
                    enabled_next = 1'b1;
                end
                if (slot_ok)
                begin
                    wr.en   = 1'b1;
                    wr.addr = IW'(item_reg.slot);
                    wr.data = rrts_pkg::ST_READY;
                end
                state_next = S_DONE;
            end

            S_EXIT:
            begin
                if (slot_ok)
                begin
                    wr.en   = 1'b1;
                    wr.addr = IW'(item_reg.slot);
                    wr.data = rrts_pkg::ST_EMPTY;
                end
                state_next = S_DONE;
            end

            S_JOIN:
            begin
                res_next.join_done = !slot_ok || (rd_data == rrts_pkg::ST_EMPTY);
                state_next         = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            total_reg     <= '0;
            enabled_reg   <= 1'b0;
            awaiting_reg  <= 1'b1;
            main_init_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            total_reg     <= total_next;
            enabled_reg   <= enabled_next;
            awaiting_reg  <= awaiting_next;
            main_init_reg <= main_init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        cand_reg <= cand_next;
        cnt_reg  <= cnt_next;
    end

endmodule

[hw/rtl/rrts_checker.sv]
`timescale 1ns / 1ps

module rrts_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input rrts_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input rrts_pkg::result_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed under stall");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item taken while previous one still in work");

    a_switch_xor_stop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.switched && result.sched_stopped))
        else $error("tick both switched and stopped");

    a_join_alone: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.join_done |-> !result.switched && !result.sched_stopped)
        else $error("join result carries tick flags");

    a_slots_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.switched |-> result.from_slot == '0 && result.to_slot == '0)
        else $error("slots reported without a switch");

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_AT      = 550;
    localparam int HOLD_CYCLES  = 150;
    localparam int CALM_LO      = 300;
    localparam int CALM_HI      = 450;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam int ITEM_TARGET  = 800;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    rrts_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    rrts_pkg::result_t result;

    rrts_pkg::item_t   item_backlog[$];
    rrts_pkg::result_t due_results[$];

    rrts_pkg::status_t            thread_state[rrts_pkg::MAX_SLOTS];
    logic [rrts_pkg::SLOT_W-1:0]  cur_thread;
    logic [rrts_pkg::TOTAL_W-1:0] thread_count;
    logic                         sched_on;
    logic                         wait_first;
    logic                         main_up;

    int fails;
    int items_taken;
    int results_seen;
    int hold_left;
    int quiet_cycles;
    int input_stall_cycles;
    int n_switch;
    int n_same;
    int n_stop;
    int n_idle_tick;
    int n_join;

    round_robin_thread_scheduler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic rrts_pkg::result_t schedule_step(input rrts_pkg::item_t op);
        rrts_pkg::result_t res;
        int k;
        int cand;
        int chosen;
        int total;
        logic found;
        res    = '0;
        found  = 1'b0;
        chosen = 0;
        total  = int'(thread_count);
        case (op.mode)
            rrts_pkg::MODE_TICK:
            begin
                if (!sched_on || total == 0)
                begin
                    n_idle_tick++;
                end
                else
                begin
                    for (k = 1; k <= total; k++)
                    begin
                        cand = (int'(cur_thread) + k) % total;
                        if (!found && cand < rrts_pkg::MAX_SLOTS &&
                            thread_state[cand] == rrts_pkg::ST_READY)
                        begin
                            chosen = cand;
                            found  = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        sched_on      = 1'b0;
                        wait_first    = 1'b1;
                        res.sched_stopped = 1'b1;
                        n_stop++;
                    end
                    else
                    begin
                        if (int'(cur_thread) < rrts_pkg::MAX_SLOTS &&
                            thread_state[cur_thread] == rrts_pkg::ST_RUN)
                            thread_state[cur_thread] = rrts_pkg::ST_READY;
                        thread_state[chosen] = rrts_pkg::ST_RUN;
                        res.switched  = 1'b1;
                        res.from_slot = cur_thread;
                        res.to_slot   = rrts_pkg::SLOT_W'(chosen);
                        if (int'(cur_thread) == chosen)
                            n_same++;
                        cur_thread = rrts_pkg::SLOT_W'(chosen);
                        n_switch++;
                    end
                end
            end
            rrts_pkg::MODE_CREATE:
            begin
                if (wait_first)
                begin
                    if (!main_up)
                    begin
                        cur_thread      = '0;
                        thread_state[0] = rrts_pkg::ST_RUN;
                        main_up         = 1'b1;
                    end
                    total = int'(op.last_slot) + 1;
                    if (total > rrts_pkg::MAX_SLOTS)
                        total = rrts_pkg::MAX_SLOTS;
                    thread_count = rrts_pkg::TOTAL_W'(total);
                    wait_first   = 1'b0;
                end
                if (int'(op.slot) < rrts_pkg::MAX_SLOTS)
                    thread_state[op.slot] = rrts_pkg::ST_READY;
                if (int'(op.slot) + 1 == int'(thread_count))
                    sched_on = 1'b1;
            end
            rrts_pkg::MODE_EXIT:
            begin
                if (int'(op.slot) < rrts_pkg::MAX_SLOTS)
                    thread_state[op.slot] = rrts_pkg::ST_EMPTY;
            end
            default:
            begin
                n_join++;
                if (int'(op.slot) < rrts_pkg::MAX_SLOTS)
                    res.join_done = (thread_state[op.slot] == rrts_pkg::ST_EMPTY);
                else
                    res.join_done = 1'b1;
            end
        endcase
        return res;
    endfunction

    task automatic queue_op(input logic [1:0] m, input int s, input int l);
        rrts_pkg::item_t op;
        op.mode      = m;
        op.slot      = rrts_pkg::SLOT_W'(s);
        op.last_slot = rrts_pkg::SLOT_W'(l);
        item_backlog.push_back(op);
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                 results_seen, what, got, want);
        fails++;
    endtask

    always @(posedge clk)
    begin : drive_items
        logic            taken;
        logic            next_valid;
        rrts_pkg::item_t next_item;
        taken      = item_valid && !item_stall;
        next_valid = item_valid;
        next_item  = item;
        if (rst_n)
        begin
            if (taken)
            begin
                due_results.push_back(schedule_step(item));
                items_taken++;
            end
            if (!item_valid || taken)
            begin
                if (item_backlog.size() > 0 &&
                    ((items_taken >= CALM_LO && items_taken < CALM_HI) ||
                     $urandom_range(0, 99) >= 37))
                begin
                    next_valid = 1'b1;
                    next_item  = item_backlog.pop_front();
                end
                else
                begin
                    next_valid = 1'b0;
                end
            end
        end
        item_valid <= next_valid;
        item       <= next_item;
    end

    always @(posedge clk)
    begin : watch_results
        rrts_pkg::result_t want;
        logic              next_stall;
        next_stall = result_stall;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                begin
                    flag_mismatch("beat with nothing pending", 1, 0);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.switched !== want.switched)
                        flag_mismatch("switched", result.switched, want.switched);
                    if (result.from_slot !== want.from_slot)
                        flag_mismatch("from_slot", result.from_slot, want.from_slot);
                    if (result.to_slot !== want.to_slot)
                        flag_mismatch("to_slot", result.to_slot, want.to_slot);
                    if (result.join_done !== want.join_done)
                        flag_mismatch("join_done", result.join_done, want.join_done);
                    if (result.sched_stopped !== want.sched_stopped)
                        flag_mismatch("sched_stopped", result.sched_stopped,
                                      want.sched_stopped);
                end
                results_seen++;
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                next_stall = 1'b1;
                hold_left--;
            end
            else if (results_seen >= CALM_LO && results_seen < CALM_HI)
                next_stall = 1'b0;
            else
                next_stall = ($urandom_range(0, 99) < 37);
        end
        result_stall <= next_stall;
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if (item_valid && item_stall)
                input_stall_cycles++;
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles, %0d results pending",
                         quiet_cycles, due_results.size());
                $display("round_robin_thread_scheduler verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int top;
        int start;
        int body;
        int pick;
        int i;
        int n;

        for (i = 0; i < rrts_pkg::MAX_SLOTS; i++)
            thread_state[i] = rrts_pkg::ST_EMPTY;
        cur_thread   = '0;
        thread_count = '0;
        sched_on     = 1'b0;
        wait_first   = 1'b1;
        main_up      = 1'b0;

        // directed: idle tick, first create, wrap, self switch, stop, restart
        queue_op(rrts_pkg::MODE_JOIN,   0, 0);
        queue_op(rrts_pkg::MODE_TICK,   0, 0);
        queue_op(rrts_pkg::MODE_CREATE, 2, 3);
        queue_op(rrts_pkg::MODE_CREATE, 3, 15);
        queue_op(rrts_pkg::MODE_TICK,   0, 0);
        queue_op(rrts_pkg::MODE_JOIN,   2, 0);
        queue_op(rrts_pkg::MODE_EXIT,   3, 0);
        queue_op(rrts_pkg::MODE_TICK,   0, 0);
        queue_op(rrts_pkg::MODE_EXIT,   2, 0);
        queue_op(rrts_pkg::MODE_EXIT,   0, 0);
        queue_op(rrts_pkg::MODE_CREATE, 0, 0);
        queue_op(rrts_pkg::MODE_TICK,   0, 0);
        queue_op(rrts_pkg::MODE_EXIT,   0, 0);
        queue_op(rrts_pkg::MODE_TICK,   0, 0);
        queue_op(rrts_pkg::MODE_CREATE, 15, 15);
        queue_op(rrts_pkg::MODE_TICK,   15, 15);
        queue_op(rrts_pkg::MODE_CREATE, 5, 0);
        queue_op(rrts_pkg::MODE_TICK,   0, 0);
        queue_op(rrts_pkg::MODE_EXIT,   15, 0);
        queue_op(rrts_pkg::MODE_EXIT,   5, 0);
        queue_op(rrts_pkg::MODE_TICK,   0, 0);
        queue_op(rrts_pkg::MODE_CREATE, 1, 1);
        queue_op(rrts_pkg::MODE_TICK,   0, 0);
        queue_op(rrts_pkg::MODE_JOIN,   15, 15);
        queue_op(rrts_pkg::MODE_JOIN,   1, 0);

        while (item_backlog.size() < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                top   = ($urandom_range(0, 7) == 0) ? 15 : $urandom_range(0, 5);
                start = $urandom_range(0, top);
                for (i = 0; i <= top; i++)
                    queue_op(rrts_pkg::MODE_CREATE, (start + i) % (top + 1), top);
                body = $urandom_range(4, 20);
                for (i = 0; i < body; i++)
                begin
                    pick = $urandom_range(0, 99);
                    n    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, top);
                    if (pick < 50)
                        queue_op(rrts_pkg::MODE_TICK, n, $urandom_range(0, 15));
                    else if (pick < 65)
                        queue_op(rrts_pkg::MODE_CREATE, n, $urandom_range(0, 15));
                    else if (pick < 80)
                        queue_op(rrts_pkg::MODE_EXIT, n, $urandom_range(0, 15));
                    else
                        queue_op(rrts_pkg::MODE_JOIN, n, $urandom_range(0, 15));
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    for (i = 0; i <= top; i++)
                        queue_op(rrts_pkg::MODE_EXIT, i, $urandom_range(0, 15));
                    queue_op(rrts_pkg::MODE_TICK, 0, 0);
                end
            end
            else
            begin
                for (i = 0; i < 10; i++)
                    queue_op(2'($urandom_range(0, 3)), $urandom_range(0, 15),
                             $urandom_range(0, 15));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (item_backlog.size() != 0 || item_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d items: %0d switches (%0d back onto the same slot), %0d stops,",
                 items_taken, n_switch, n_same, n_stop);
        $display("%0d ticks while idle, %0d joins, input held off for %0d cycles",
                 n_idle_tick, n_join, input_stall_cycles);
        if (fails == 0)
            $display("round_robin_thread_scheduler verification clean");
        else
            $display("round_robin_thread_scheduler verification failed");
        $finish;
    end

endmodule
